[src/crrb_pkg.sv]
// Shared types and constants for the record ring buffer space manager.
package crrb_pkg;

  // Fixed field widths
  localparam int unsigned CAP_W   = 17;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned REQ_W   = 16;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned TOTAL_W = 17;
  localparam int unsigned LEN_W   = 17;

  localparam int unsigned MIN_CAPACITY = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;

  // Parameter defaults
  localparam int unsigned BUFFER_BYTES_DEF = 65536;
  localparam int unsigned MAX_RECORDS_DEF  = 1024;
  localparam int unsigned HEADER_BYTES_DEF = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESERVE = 3'd0,
    MODE_COMMIT  = 3'd1,
    MODE_READ    = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_QUERY   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_TOO_BIG  = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [OFF_W-1:0]    payload_offset;
    logic [OFF_W-1:0]    payload_length;
    logic [COUNT_W-1:0]  record_count;
    logic [TOTAL_W-1:0]  payload_total;
  } rsp_t;

endpackage

[src/crrb_req_if.sv]
// Request channel: mode and payload length, valid/ready handshake.
interface crrb_req_if
  import crrb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [REQ_W-1:0]  request_length;

  modport source (output valid, mode, request_length, input ready);
  modport sink   (input valid, mode, request_length, output ready);
endinterface

[src/crrb_rsp_if.sv]
// Result channel: status, offsets and running totals, valid/ready handshake.
interface crrb_rsp_if
  import crrb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [OFF_W-1:0]   payload_offset;
  logic [OFF_W-1:0]   payload_length;
  logic [COUNT_W-1:0] record_count;
  logic [TOTAL_W-1:0] payload_total;

  modport source (output valid, status, payload_offset, payload_length, record_count,
                  payload_total, input ready);
  modport sink   (input valid, status, payload_offset, payload_length, record_count,
                  payload_total, output ready);
endinterface

[src/crrb_cfg_if.sv]
// Configuration write channel for the capacity register.
interface crrb_cfg_if
  import crrb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_bytes;

  modport source (output valid, capacity_bytes, input ready);
  modport sink   (input valid, capacity_bytes, output ready);
endinterface

[src/crrb_len_fifo.sv]
// Record length store: one write port, one registered read port with write bypass.
module crrb_len_fifo
  import crrb_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_RECORDS_DEF,
  parameter int unsigned IDX_W = $clog2(MAX_RECORDS_DEF)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [LEN_W-1:0] wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [LEN_W-1:0] rdata_o
);

  logic [LEN_W-1:0] mem [DEPTH];
  logic [LEN_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read address is the next head, so rdata_q always shows the current front entry
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/crrb_ctrl.sv]
// Pointer state, space check and counters: one request resolved per cycle.
module crrb_ctrl
  import crrb_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int unsigned MAX_RECORDS  = MAX_RECORDS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int unsigned IDX_W        = $clog2(MAX_RECORDS_DEF)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic [MODE_W-1:0]  mode_i,
  input  logic [REQ_W-1:0]   req_len_i,
  input  logic [CAP_W-1:0]   cap_cfg_i,
  input  logic [LEN_W-1:0]   head_len_i,
  output logic               fifo_we_o,
  output logic [IDX_W-1:0]   fifo_waddr_o,
  output logic [LEN_W-1:0]   fifo_wdata_o,
  output logic [IDX_W-1:0]   fifo_raddr_o,
  output rsp_t               rsp_o
);

  localparam int unsigned BUF_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned PW    = (BUF_W > CAP_W) ? BUF_W : CAP_W;
  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);

  localparam logic [PW-1:0]    BufMax = PW'(BUFFER_BYTES);
  localparam logic [PW-1:0]    CapMin = PW'(MIN_CAPACITY);
  localparam logic [PW-1:0]    HdrPos = PW'(HEADER_BYTES);
  localparam logic [LEN_W-1:0] HdrLen = LEN_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_RECORDS);
  localparam logic [IDX_W-1:0] IdxLast = IDX_W'(MAX_RECORDS - 1);

  logic [PW-1:0]      w_q, w_d, r_q, r_d, wrap_q, wrap_d;
  logic [IDX_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TOTAL_W-1:0] bytes_q, bytes_d;

  logic [PW-1:0]      cap, cap_raw, total_p, free0, free1;
  logic [PW-1:0]      w_t, r_t, wrap_t, off_p, rel_r;
  logic [LEN_W-1:0]   total, plen_l, rel_pay;
  logic               too_big, full, empty;
  logic [CNT_W+COUNT_W-1:0] cnt_x;

  function automatic logic [PW-1:0] free_fn(input logic [PW-1:0] w, input logic [PW-1:0] r,
                                            input logic [PW-1:0] wr, input logic [PW-1:0] c);
    logic [PW-1:0] f;
    if (w < r) begin
      f = r - w;
    end else if ((w == r) && (wr != '0)) begin
      f = '0;
    end else if (w < c) begin
      f = c - w;
    end else begin
      f = '0;
    end
    return f;
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IdxLast) ? '0 : i + IDX_W'(1);
  endfunction

  always_comb begin
    cap_raw = PW'(cap_cfg_i);
    if (cap_raw > BufMax) begin
      cap = BufMax;
    end else if (cap_raw < CapMin) begin
      cap = CapMin;
    end else begin
      cap = cap_raw;
    end
  end

  assign total   = LEN_W'(req_len_i) + HdrLen;
  assign total_p = PW'(total);
  assign too_big = total_p > cap;
  assign full    = cnt_q >= CntMax;
  assign empty   = cnt_q == '0;
  assign free0   = free_fn(w_q, r_q, wrap_q, cap);
  assign rel_pay = head_len_i - HdrLen;
  assign rel_r   = r_q + PW'(head_len_i);

  always_comb begin
    w_d = w_q;
    r_d = r_q;
    wrap_d = wrap_q;
    head_d = head_q;
    tail_d = tail_q;
    cnt_d = cnt_q;
    bytes_d = bytes_q;
    fifo_we_o = 1'b0;
    rsp_o.status = ST_OK;
    off_p = '0;
    plen_l = '0;
    w_t = w_q;
    r_t = r_q;
    wrap_t = wrap_q;

    // Early wrap for a reservation that does not fit before the end
    if ((free0 < total_p) && (wrap_q == '0)) begin
      if (w_q == r_q) begin
        r_t = '0;
        wrap_t = '0;
      end else begin
        wrap_t = w_q;
      end
      w_t = '0;
    end
    free1 = free_fn(w_t, r_t, wrap_t, cap);

    if (acc_i) begin
      unique case (mode_e'(mode_i))
        MODE_RESERVE: begin
          if (too_big) begin
            rsp_o.status = ST_TOO_BIG;
          end else if (full) begin
            rsp_o.status = ST_NO_SPACE;
          end else begin
            w_d = w_t;
            r_d = r_t;
            wrap_d = wrap_t;
            if (free1 >= total_p) begin
              off_p = w_t + HdrPos;
            end else begin
              rsp_o.status = ST_NO_SPACE;
            end
          end
        end
        MODE_COMMIT: begin
          if (too_big) begin
            rsp_o.status = ST_TOO_BIG;
          end else if (full || (free0 < total_p)) begin
            rsp_o.status = ST_NO_SPACE;
          end else begin
            fifo_we_o = 1'b1;
            tail_d = next_idx(tail_q);
            cnt_d = cnt_q + CNT_W'(1);
            bytes_d = bytes_q + TOTAL_W'(req_len_i);
            w_d = w_q + total_p;
          end
        end
        MODE_READ: begin
          if (empty) begin
            rsp_o.status = ST_EMPTY;
          end else begin
            off_p = r_q + HdrPos;
            plen_l = rel_pay;
          end
        end
        MODE_RELEASE: begin
          if (empty) begin
            rsp_o.status = ST_EMPTY;
          end else begin
            head_d = next_idx(head_q);
            cnt_d = cnt_q - CNT_W'(1);
            bytes_d = bytes_q - TOTAL_W'(rel_pay);
            r_d = rel_r;
            if ((wrap_q != '0) && (rel_r >= wrap_q)) begin
              wrap_d = '0;
              r_d = '0;
            end
          end
        end
        default: begin
          // query and unused modes only report the counters
        end
      endcase
    end

    cnt_x = {{COUNT_W{1'b0}}, cnt_d};
    rsp_o.payload_offset = off_p[OFF_W-1:0];
    rsp_o.payload_length = plen_l[OFF_W-1:0];
    rsp_o.record_count = cnt_x[COUNT_W-1:0];
    rsp_o.payload_total = bytes_d;
  end

  assign fifo_waddr_o = tail_q;
  assign fifo_wdata_o = total;
  assign fifo_raddr_o = head_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
      r_q <= '0;
      wrap_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      cnt_q <= '0;
      bytes_q <= '0;
    end else begin
      w_q <= w_d;
      r_q <= r_d;
      wrap_q <= wrap_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q <= cnt_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

[src/contiguous_record_ring_buffer_core.sv]
// Top level of the record ring buffer space manager.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    mode, request_length
//   rsp_o    out  valid/ready    status, payload_offset, payload_length,
//                                record_count, payload_total
//   cfg_i    in   valid/ready    capacity_bytes (always ready)
//
// One request per cycle unless req_i stalls: each is resolved in the cycle it is
// transferred and its result appears in the output register on the next cycle.
// The length store read is registered on the next head, ahead of its use.
// Reset clears pointers and counters; the length store is not cleared.
// req_i stalls only while a result sits unconsumed in the output register.
module contiguous_record_ring_buffer_core
  import crrb_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int unsigned MAX_RECORDS  = MAX_RECORDS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crrb_req_if.sink    req_i,
  crrb_rsp_if.source  rsp_o,
  crrb_cfg_if.sink    cfg_i
);

  localparam int unsigned IDX_W = $clog2(MAX_RECORDS);

  logic [CAP_W-1:0] cap_q;
  logic             acc;
  logic             rsp_valid_q, rsp_valid_d;
  rsp_t             rsp_q, rsp_d;
  logic             fifo_we;
  logic [IDX_W-1:0] fifo_waddr, fifo_raddr;
  logic [LEN_W-1:0] fifo_wdata, head_len;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.capacity_bytes;
    end
  end

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign acc = req_i.valid && req_i.ready;

  crrb_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_RECORDS  (MAX_RECORDS),
    .HEADER_BYTES (HEADER_BYTES),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .mode_i       (req_i.mode),
    .req_len_i    (req_i.request_length),
    .cap_cfg_i    (cap_q),
    .head_len_i   (head_len),
    .fifo_we_o    (fifo_we),
    .fifo_waddr_o (fifo_waddr),
    .fifo_wdata_o (fifo_wdata),
    .fifo_raddr_o (fifo_raddr),
    .rsp_o        (rsp_d)
  );

  crrb_len_fifo #(
    .DEPTH (MAX_RECORDS),
    .IDX_W (IDX_W)
  ) u_len_fifo (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .raddr_i (fifo_raddr),
    .rdata_o (head_len)
  );

  assign rsp_valid_d = acc || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_q.status;
  assign rsp_o.payload_offset = rsp_q.payload_offset;
  assign rsp_o.payload_length = rsp_q.payload_length;
  assign rsp_o.record_count   = rsp_q.record_count;
  assign rsp_o.payload_total  = rsp_q.payload_total;

  // A transfer on req_i always leaves a result waiting
  a_acc_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> rsp_valid_q)
    else $error("request transfer without a following result");

  // Input only stalls behind an unconsumed result
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (rsp_valid_q && !rsp_o.ready))
    else $error("request channel stalled without a pending result");

  // An empty-queue answer carries no offset, no length and a zero count
  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_q.status == ST_EMPTY)) |->
      ((rsp_q.payload_offset == '0) && (rsp_q.payload_length == '0) &&
       (rsp_q.record_count == '0)))
    else $error("empty-queue result with non-zero fields");

endmodule
